### design/servo_speed_command_parser_defines.svh
// Assertion macros shared by the checker.
`ifndef SERVO_SPEED_COMMAND_PARSER_DEFINES_SVH
`define SERVO_SPEED_COMMAND_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SSCP_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SSCP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/sscp_pkg.sv
package sscp_pkg;

  localparam int MSG_DEPTH_DEF = 128;
  localparam int MAX_ACT_DEF   = 32;

  // Servo counter / limit width, covers the 6-bit register and up to 64 servos.
  localparam int LIM_W = 7;

  localparam logic [5:0] ACT_CNT_RST = 6'd18;

  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  // floor(x/100) == (x*5243)>>19 for x up to 16256.
  localparam logic [12:0] SPD_RECIP = 13'd5243;
  localparam int          SPD_SHIFT = 19;
  localparam int          PROD_W    = 29;

  localparam logic [7:0] HEX_OFS = 8'd55;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_FIRST,
    ST_G_HI,
    ST_G_LO,
    ST_G_NXT,
    ST_S_SRV,
    ST_S_SIGN,
    ST_S_PCT,
    ST_EMIT
  } state_t;

  function automatic logic [7:0] hex_val(input logic [7:0] c);
    logic [7:0] r;
    if (c >= CH_A) begin
      r = c - HEX_OFS;
    end else begin
      r = {4'h0, c[3:0]};
    end
    return r;
  endfunction

  function automatic logic [7:0] dec_acc(input logic [7:0] v, input logic [7:0] c);
    return {v[4:0], 3'b000} + {v[6:0], 1'b0} + {4'h0, c[3:0]};
  endfunction

endpackage

### design/servo_speed_command_parser.sv
// Ordinary bytes: stored while idle; the input stays ready for the next byte.
// LF: the line is walked byte by byte via FETCH (single read port, registered data).
//   Group line: G_HI, G_LO, G_NXT, EMIT per word; single: S_SRV, S_SIGN, S_PCT, EMIT.
// Input is not ready while a line is walked; a word waits in the output register.
// Reset (rst_n low, synchronous): line empty, overflow cleared, actuator_count = 18.
module servo_speed_command_parser #(
  parameter int MSG_DEPTH     = sscp_pkg::MSG_DEPTH_DEF,
  parameter int MAX_ACTUATORS = sscp_pkg::MAX_ACT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_servo_index,
  output logic signed [7:0] out_percent_value,
  output logic signed [7:0] out_speed_value,
  output logic              out_line_kind,
  output logic              out_last_of_run,
  input  logic              cfg_wr_en,
  input  logic [5:0]        cfg_wr_data
);

  localparam int FILL_W = $clog2(MSG_DEPTH + 1);
  localparam int ADDR_W = $clog2(MSG_DEPTH);
  localparam int LIM_W  = sscp_pkg::LIM_W;
  localparam int PW     = sscp_pkg::PROD_W;

  logic [7:0] mem [MSG_DEPTH];
  logic [7:0] rd_data_r;
  logic       rd_vld_r;

  sscp_pkg::state_t state_r, state_nxt, ret_r, ret_nxt;

  logic [FILL_W-1:0] fill_r, fill_nxt, len_r, len_nxt, idx_r, idx_nxt;
  logic              ovf_r, ovf_nxt;
  logic [5:0]        act_cnt_r;
  logic [LIM_W-1:0]  gsrv_r, gsrv_nxt;
  logic [7:0]        ssrv_r, ssrv_nxt, pct_r, pct_nxt;
  logic              neg_r, neg_nxt, last_r, last_nxt, kind_r, kind_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_srv_r, out_srv_nxt, out_pct_r, out_pct_nxt;
  logic              out_kind_r, out_kind_nxt, out_last_r, out_last_nxt;
  logic [PW-1:0]     out_prod_r, out_prod_nxt;

  logic              acc, wr_en, out_free;
  logic [7:0]        b, hex_b;
  logic [LIM_W-1:0]  lim, gsrv_inc;
  logic              srv_ok, is_digit, g_ok;
  logic [8:0]        mag;
  logic [15:0]       mag127;
  logic [PW-1:0]     prod;
  logic [9:0]        q;

  assign in_ready = (state_r == sscp_pkg::ST_IDLE);
  assign acc      = in_valid && in_ready;
  assign wr_en    = acc && (in_rx_byte != sscp_pkg::CH_CR) && (in_rx_byte != sscp_pkg::CH_LF) &&
                    (in_rx_byte != sscp_pkg::CH_HASH) && (fill_r < FILL_W'(MSG_DEPTH));
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill_r[ADDR_W-1:0]] <= in_rx_byte;
    end
    rd_data_r <= mem[idx_r[ADDR_W-1:0]];
    rd_vld_r  <= (idx_r < len_r);
  end

  assign b        = rd_vld_r ? rd_data_r : 8'h00;
  assign hex_b    = sscp_pkg::hex_val(b);
  assign is_digit = (b >= sscp_pkg::CH_0) && (b <= sscp_pkg::CH_9);
  assign g_ok     = (b == sscp_pkg::CH_G) && (len_r >= FILL_W'(3)) && len_r[0];
  assign lim      = ({1'b0, act_cnt_r} > LIM_W'(MAX_ACTUATORS)) ? LIM_W'(MAX_ACTUATORS)
                                                                 : {1'b0, act_cnt_r};
  assign gsrv_inc = gsrv_r + LIM_W'(1);
  assign srv_ok   = (gsrv_r < lim) && (b != 8'h00);

  assign mag    = pct_r[7] ? (9'd256 - {1'b0, pct_r}) : {1'b0, pct_r};
  assign mag127 = {mag, 7'b0} - {7'b0, mag};
  assign prod   = {13'b0, mag127} * {16'b0, sscp_pkg::SPD_RECIP};

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    unique case (state_r)
      sscp_pkg::ST_IDLE: begin
        if (acc && (in_rx_byte == sscp_pkg::CH_LF) && !ovf_r) begin
          state_nxt = sscp_pkg::ST_FETCH;
          ret_nxt   = sscp_pkg::ST_FIRST;
        end
      end
      sscp_pkg::ST_FETCH: state_nxt = ret_r;
      sscp_pkg::ST_FIRST: begin
        if (g_ok) begin
          state_nxt = sscp_pkg::ST_FETCH;
          ret_nxt   = sscp_pkg::ST_G_HI;
        end else if (b == sscp_pkg::CH_S) begin
          state_nxt = sscp_pkg::ST_FETCH;
          ret_nxt   = sscp_pkg::ST_S_SRV;
        end else begin
          state_nxt = sscp_pkg::ST_IDLE;
        end
      end
      sscp_pkg::ST_G_HI: begin
        if (srv_ok) begin
          state_nxt = sscp_pkg::ST_FETCH;
          ret_nxt   = sscp_pkg::ST_G_LO;
        end else begin
          state_nxt = sscp_pkg::ST_IDLE;
        end
      end
      sscp_pkg::ST_G_LO: begin
        state_nxt = sscp_pkg::ST_FETCH;
        ret_nxt   = sscp_pkg::ST_G_NXT;
      end
      sscp_pkg::ST_G_NXT: state_nxt = sscp_pkg::ST_EMIT;
      sscp_pkg::ST_S_SRV: begin
        if (is_digit) begin
          state_nxt = sscp_pkg::ST_FETCH;
          ret_nxt   = sscp_pkg::ST_S_SRV;
        end else if (b == sscp_pkg::CH_COMMA) begin
          state_nxt = sscp_pkg::ST_FETCH;
          ret_nxt   = sscp_pkg::ST_S_SIGN;
        end else begin
          state_nxt = sscp_pkg::ST_IDLE;
        end
      end
      sscp_pkg::ST_S_SIGN: begin
        if (b == sscp_pkg::CH_MINUS) begin
          state_nxt = sscp_pkg::ST_FETCH;
          ret_nxt   = sscp_pkg::ST_S_PCT;
        end else begin
          state_nxt = sscp_pkg::ST_S_PCT;
        end
      end
      sscp_pkg::ST_S_PCT: begin
        if (b != 8'h00) begin
          state_nxt = sscp_pkg::ST_FETCH;
          ret_nxt   = sscp_pkg::ST_S_PCT;
        end else begin
          state_nxt = sscp_pkg::ST_EMIT;
        end
      end
      sscp_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = last_r ? sscp_pkg::ST_IDLE : sscp_pkg::ST_G_HI;
        end
      end
      default: state_nxt = sscp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    fill_nxt      = fill_r;
    ovf_nxt       = ovf_r;
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    gsrv_nxt      = gsrv_r;
    ssrv_nxt      = ssrv_r;
    pct_nxt       = pct_r;
    neg_nxt       = neg_r;
    last_nxt      = last_r;
    kind_nxt      = kind_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_srv_nxt   = out_srv_r;
    out_pct_nxt   = out_pct_r;
    out_kind_nxt  = out_kind_r;
    out_last_nxt  = out_last_r;
    out_prod_nxt  = out_prod_r;
    unique case (state_r)
      sscp_pkg::ST_IDLE: begin
        if (acc) begin
          if ((in_rx_byte == sscp_pkg::CH_LF) || (in_rx_byte == sscp_pkg::CH_HASH)) begin
            fill_nxt = '0;
            ovf_nxt  = 1'b0;
            len_nxt  = fill_r;
            idx_nxt  = '0;
          end else if (in_rx_byte != sscp_pkg::CH_CR) begin
            if (wr_en) begin
              fill_nxt = fill_r + FILL_W'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
        end
      end
      sscp_pkg::ST_FETCH: ;
      sscp_pkg::ST_FIRST: begin
        idx_nxt  = FILL_W'(1);
        gsrv_nxt = '0;
        ssrv_nxt = '0;
        pct_nxt  = '0;
        neg_nxt  = 1'b0;
        kind_nxt = !g_ok;
      end
      sscp_pkg::ST_G_HI: begin
        if (srv_ok) begin
          pct_nxt = {hex_b[3:0], 4'h0};
          idx_nxt = idx_r + FILL_W'(1);
        end
      end
      sscp_pkg::ST_G_LO: begin
        pct_nxt = pct_r | hex_b;
        idx_nxt = idx_r + FILL_W'(1);
      end
      sscp_pkg::ST_G_NXT: last_nxt = !((gsrv_inc < lim) && (b != 8'h00));
      sscp_pkg::ST_S_SRV: begin
        if (is_digit) begin
          ssrv_nxt = sscp_pkg::dec_acc(ssrv_r, b);
          idx_nxt  = idx_r + FILL_W'(1);
        end else if (b == sscp_pkg::CH_COMMA) begin
          idx_nxt = idx_r + FILL_W'(1);
        end
      end
      sscp_pkg::ST_S_SIGN: begin
        if (b == sscp_pkg::CH_MINUS) begin
          neg_nxt = 1'b1;
          idx_nxt = idx_r + FILL_W'(1);
        end
      end
      sscp_pkg::ST_S_PCT: begin
        if (b != 8'h00) begin
          pct_nxt = sscp_pkg::dec_acc(pct_r, b);
          idx_nxt = idx_r + FILL_W'(1);
        end else begin
          if (neg_r) begin
            pct_nxt = 8'h00 - pct_r;
          end
          last_nxt = 1'b1;
        end
      end
      sscp_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_srv_nxt   = kind_r ? ssrv_r : {1'b0, gsrv_r};
          out_pct_nxt   = pct_r;
          out_kind_nxt  = kind_r;
          out_last_nxt  = last_r;
          out_prod_nxt  = prod;
          gsrv_nxt      = gsrv_inc;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sscp_pkg::ST_IDLE;
      ret_r       <= sscp_pkg::ST_IDLE;
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      len_r       <= '0;
      act_cnt_r   <= sscp_pkg::ACT_CNT_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      fill_r      <= fill_nxt;
      ovf_r       <= ovf_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        act_cnt_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    gsrv_r     <= gsrv_nxt;
    ssrv_r     <= ssrv_nxt;
    pct_r      <= pct_nxt;
    neg_r      <= neg_nxt;
    last_r     <= last_nxt;
    kind_r     <= kind_nxt;
    out_srv_r  <= out_srv_nxt;
    out_pct_r  <= out_pct_nxt;
    out_kind_r <= out_kind_nxt;
    out_last_r <= out_last_nxt;
    out_prod_r <= out_prod_nxt;
  end

  // speed = sign(pct) * sat(floor(|pct|*127/100))
  assign q = out_prod_r[PW-1:sscp_pkg::SPD_SHIFT];

  always_comb begin
    if (out_pct_r[7]) begin
      out_speed_value = (q > 10'd128) ? 8'sh80 : $signed(8'(10'd0 - q));
    end else begin
      out_speed_value = (q > 10'd127) ? 8'sh7F : $signed(q[7:0]);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_servo_index   = out_srv_r;
  assign out_percent_value = $signed(out_pct_r);
  assign out_line_kind     = out_kind_r;
  assign out_last_of_run   = out_last_r;

endmodule

### design/sscp_checker.sv
`include "servo_speed_command_parser_defines.svh"

module sscp_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [7:0]        in_rx_byte,
  input logic              out_valid,
  input logic              out_ready,
  input logic [7:0]        out_servo_index,
  input logic signed [7:0] out_percent_value,
  input logic signed [7:0] out_speed_value,
  input logic              out_line_kind,
  input logic              out_last_of_run
);

  logic [25:0] out_word;
  logic        out_stall, plain_acc, sign_ok;

  assign out_word  = {out_servo_index, out_percent_value, out_speed_value,
                      out_line_kind, out_last_of_run};
  assign out_stall = out_valid && !out_ready;
  assign plain_acc = in_valid && in_ready && (in_rx_byte != sscp_pkg::CH_LF);
  assign sign_ok   = (out_speed_value[7] == out_percent_value[7]);

  `SSCP_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_word), "stalled word changed")

  `SSCP_ASSERT(a_single_last, out_valid && out_line_kind, out_last_of_run, "single word not last")

  `SSCP_ASSERT(a_speed_sign, out_valid, sign_ok, "speed sign differs from percent sign")

  `SSCP_ASSERT_NEXT(a_no_word_wo_lf, plain_acc, !$rose(out_valid), "result word without line end")

endmodule

bind servo_speed_command_parser sscp_checker u_sscp_checker (.*);

### tb/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int LINE_DEPTH       = sscp_pkg::MSG_DEPTH_DEF;
  localparam int MAX_SERVOS       = sscp_pkg::MAX_ACT_DEF;
  localparam bit KIND_GROUP       = 1'b0;
  localparam bit KIND_SINGLE      = 1'b1;
  localparam int HOLD_CYCLES      = 500;
  localparam int LINE_WALK_CYCLES = 400;
  localparam int STALL_LIMIT      = 20000;
  localparam int STEADY_LINES     = 5;
  localparam int RANDOM_LINES     = 4;
  localparam int MAX_PRINTED      = 40;
  localparam string HEX_DIGITS    = "0123456789ABCDEFabcdef";

  typedef struct {
    logic [7:0] servo;
    byte        pct;
    byte        speed;
    bit         kind;
    bit         last;
  } speed_word_t;

  logic              clk;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  logic [7:0]        in_rx_byte  = 8'h00;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  logic [7:0]        out_servo_index;
  logic signed [7:0] out_percent_value;
  logic signed [7:0] out_speed_value;
  logic              out_line_kind;
  logic              out_last_of_run;
  logic              cfg_wr_en   = 1'b0;
  logic [5:0]        cfg_wr_data = '0;

  // predictor state
  logic [7:0]  line_store [LINE_DEPTH];
  int unsigned line_len      = 0;
  bit          line_overflow = 1'b0;
  logic [5:0]  servo_limit   = sscp_pkg::ACT_CNT_RST;
  speed_word_t pending_speeds [$];

  int   errors        = 0;
  int   quiet_cycles  = 0;
  bit   tx_steady     = 1'b0;
  logic rx_steady     = 1'b0;
  int   hold_requests = 0;
  int   holds_served  = 0;
  int   hold_left     = 0;

  servo_speed_command_parser i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_servo_index   (out_servo_index),
    .out_percent_value (out_percent_value),
    .out_speed_value   (out_speed_value),
    .out_line_kind     (out_line_kind),
    .out_last_of_run   (out_last_of_run),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------- predictor ----------------

  function automatic logic [7:0] line_at(input int unsigned pos);
    return (pos < line_len) ? line_store[pos] : 8'h00;
  endfunction

  function automatic logic [7:0] hex_value(input logic [7:0] c);
    if (c >= sscp_pkg::CH_A) begin
      return 8'(c - sscp_pkg::CH_A + 8'd10);
    end
    return {4'h0, c[3:0]};
  endfunction

  function automatic byte scaled_speed(input byte pct);
    int s;
    s = int'(pct) * 127 / 100;
    if (s > 127) begin
      s = 127;
    end else if (s < -128) begin
      s = -128;
    end
    return byte'(s);
  endfunction

  function automatic void decode_line();
    speed_word_t run [$];
    speed_word_t w;
    int unsigned lim, pos, srv_n;
    logic [7:0]  hi, lo, c, srv, pct;
    bit          neg;
    if (!line_overflow) begin
      if (line_at(0) == sscp_pkg::CH_G && line_len >= 3 && line_len % 2 == 1) begin
        lim = (servo_limit > MAX_SERVOS) ? MAX_SERVOS : servo_limit;
        pos = 0;
        for (srv_n = 0; srv_n < lim && line_at(pos + 1) != 8'h00; srv_n++) begin
          hi = hex_value(line_at(pos + 1));
          lo = hex_value(line_at(pos + 2));
          pos += 2;
          w.servo = 8'(srv_n);
          w.pct   = byte'({hi[3:0], 4'h0} | lo);
          w.kind  = KIND_GROUP;
          run.push_back(w);
        end
      end else if (line_at(0) == sscp_pkg::CH_S) begin
        srv = 8'h00;
        pct = 8'h00;
        neg = 1'b0;
        pos = 1;
        while (line_at(pos) >= sscp_pkg::CH_0 && line_at(pos) <= sscp_pkg::CH_9) begin
          c = line_at(pos);
          srv = 8'(srv * 10 + c[3:0]);
          pos++;
        end
        if (line_at(pos) == sscp_pkg::CH_COMMA) begin
          pos++;
          if (line_at(pos) == sscp_pkg::CH_MINUS) begin
            neg = 1'b1;
            pos++;
          end
          while (line_at(pos) != 8'h00) begin
            c = line_at(pos);
            pct = 8'(pct * 10 + c[3:0]);
            pos++;
          end
          if (neg) begin
            pct = 8'(8'h00 - pct);
          end
          w.servo = srv;
          w.pct   = byte'(pct);
          w.kind  = KIND_SINGLE;
          run.push_back(w);
        end
      end
    end
    foreach (run[k]) begin
      w = run[k];
      w.speed = scaled_speed(w.pct);
      w.last  = (k == run.size() - 1);
      pending_speeds.push_back(w);
    end
  endfunction

  function automatic void take_byte(input logic [7:0] c);
    if (c == sscp_pkg::CH_LF) begin
      decode_line();
      line_len = 0;
      line_overflow = 1'b0;
    end else if (c == sscp_pkg::CH_HASH) begin
      line_len = 0;
      line_overflow = 1'b0;
    end else if (c != sscp_pkg::CH_CR) begin
      if (line_len < LINE_DEPTH) begin
        line_store[line_len] = c;
        line_len++;
      end else begin
        line_overflow = 1'b1;
      end
    end
  endfunction

  // ---------------- checking ----------------

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= MAX_PRINTED) begin
      $display("%0t: %s got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  always @(posedge clk) begin
    speed_word_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_speeds.size() == 0) begin
        report_mismatch("word with no result pending, servo_index", out_servo_index, -1);
      end else begin
        want = pending_speeds.pop_front();
        if (out_servo_index !== want.servo)
          report_mismatch("servo_index", out_servo_index, want.servo);
        if (out_percent_value !== want.pct)
          report_mismatch("percent_value", out_percent_value, want.pct);
        if (out_speed_value !== want.speed)
          report_mismatch("speed_value", out_speed_value, want.speed);
        if (out_line_kind !== want.kind)
          report_mismatch("line_kind", out_line_kind, want.kind);
        if (out_last_of_run !== want.last)
          report_mismatch("last_of_run", out_last_of_run, want.last);
      end
    end
  end

  // receiver: random stalls, steady stretches and long hold-offs
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_requests != holds_served) begin
      holds_served <= holds_served + 1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rx_steady || ($urandom_range(99) >= 16);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------- stimulus helpers ----------------

  task automatic send_word(input logic [7:0] c);
    int gap;
    gap = 0;
    if (!tx_steady) begin
      while ($urandom_range(99) < 16) gap++;
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= c;
    do @(posedge clk); while (in_ready !== 1'b1);
    take_byte(c);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_word(s[i]);
  endtask

  task automatic send_line(input string s);
    send_text(s);
    send_word(sscp_pkg::CH_LF);
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
  endtask

  task automatic wait_drain();
    do @(posedge clk); while (pending_speeds.size() != 0);
  endtask

  task automatic set_servo_limit(input logic [5:0] value);
    idle_input();
    wait_drain();
    repeat (LINE_WALK_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    servo_limit = value;
  endtask

  function automatic logic [7:0] any_plain_byte();
    logic [7:0] c;
    do c = 8'($urandom);
    while (c == sscp_pkg::CH_CR || c == sscp_pkg::CH_LF || c == sscp_pkg::CH_HASH);
    return c;
  endfunction

  function automatic logic [7:0] hex_char();
    int r;
    r = $urandom_range(23);
    if (r < HEX_DIGITS.len()) begin
      return HEX_DIGITS[r];
    end
    return any_plain_byte();
  endfunction

  task automatic send_pairs(input int n);
    repeat (n) begin
      send_word(hex_char());
      send_word(hex_char());
    end
  endtask

  task automatic send_random_line();
    int pick, n;
    pick = $urandom_range(99);
    if (pick < 45) begin
      send_word(sscp_pkg::CH_S);
      n = $urandom_range(3);
      repeat (n) send_word(8'(sscp_pkg::CH_0 + $urandom_range(9)));
      if ($urandom_range(19) != 0) send_word(sscp_pkg::CH_COMMA);
      if ($urandom_range(1) != 0) send_word(sscp_pkg::CH_MINUS);
      n = $urandom_range(3);
      repeat (n) begin
        send_word(($urandom_range(9) == 0) ? any_plain_byte()
                                           : 8'(sscp_pkg::CH_0 + $urandom_range(9)));
      end
    end else if (pick < 80) begin
      send_word(sscp_pkg::CH_G);
      n = ($urandom_range(7) == 0) ? $urandom_range(63) : $urandom_range(8);
      send_pairs(n);
      if ($urandom_range(9) == 0) send_word(hex_char());
    end else begin
      n = ($urandom_range(29) == 0) ? $urandom_range(140, 125) : $urandom_range(10);
      repeat (n) begin
        if ($urandom_range(19) == 0) begin
          send_word(($urandom_range(1) != 0) ? sscp_pkg::CH_CR : sscp_pkg::CH_HASH);
        end else begin
          send_word(8'($urandom));
        end
      end
    end
    if ($urandom_range(4) == 0) send_word(sscp_pkg::CH_CR);
    send_word(sscp_pkg::CH_LF);
  endtask

  // ---------------- tests ----------------

  task automatic test_line_framing();
    send_word(sscp_pkg::CH_LF);
    send_word(sscp_pkg::CH_CR);
    send_word(sscp_pkg::CH_LF);
    send_line("#");
    send_line("X12");
    send_word(8'h00);
    send_line("S1,1");
    send_text("S1,2");
    send_word(8'h00);
    send_line("9");
    send_line("S9,9#S1,1");
  endtask

  task automatic test_single_lines();
    send_line("S0,0");
    send_line("S255,127");
    send_line("S1,-128");
    send_line("S2,-100");
    send_line("S3,100");
    send_line("S12,-5");
    send_line("S5,999");
    send_line("S300,1");
    send_line("S,5");
    send_line("S1,-");
    send_line("S1,");
    send_line("S12x3");
    send_text("S4,1");
    send_word(sscp_pkg::CH_CR);
    send_line("2");
    send_text("S4,-");
    send_word(8'hFF);
    send_word(sscp_pkg::CH_LF);
    // sender waits for all pending words to drain before going on
    idle_input();
    wait_drain();
  endtask

  task automatic test_group_limits();
    send_word(sscp_pkg::CH_G);
    send_pairs(19);
    send_word(sscp_pkg::CH_LF);
    send_line("G7F80");
    send_line("GFF00");
    send_line("Gaf");
    send_text("G12");
    send_word(8'h00);
    send_line("5");
    send_text("G1");
    send_word(8'h00);
    send_word(sscp_pkg::CH_LF);
    send_word(sscp_pkg::CH_G);
    send_word(8'hFF);
    send_word(8'hC3);
    send_word(sscp_pkg::CH_LF);
    send_line("G123");
    send_line("G1");
    send_line("G");
    set_servo_limit(6'd0);
    send_line("G1234");
    set_servo_limit(6'd1);
    send_line("G7F80");
    set_servo_limit(6'd63);
  endtask

  task automatic test_store_overflow();
    send_text("S7,");
    repeat (LINE_DEPTH - 3) send_word("1");
    send_word(sscp_pkg::CH_LF);
    send_text("S7,");
    repeat (LINE_DEPTH - 2) send_word("1");
    send_word(sscp_pkg::CH_LF);
    send_line("S2,50");
  endtask

  task automatic test_backpressure();
    hold_requests <= hold_requests + 1;
    // count above the servo ceiling, run stops at MAX_SERVOS
    send_word(sscp_pkg::CH_G);
    send_pairs(MAX_SERVOS + 1);
    send_word(sscp_pkg::CH_LF);
    repeat (2) send_random_line();
    idle_input();
    wait_drain();
  endtask

  task automatic test_steady_stream();
    tx_steady = 1'b1;
    rx_steady <= 1'b1;
    repeat (STEADY_LINES) send_random_line();
    tx_steady = 1'b0;
    rx_steady <= 1'b0;
  endtask

  task automatic test_random_traffic();
    repeat (RANDOM_LINES) begin
      send_random_line();
      if ($urandom_range(2) == 0) begin
        idle_input();
        wait_drain();
      end
      if ($urandom_range(3) == 0) set_servo_limit(6'($urandom_range(63)));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_line_framing();
    test_single_lines();
    test_group_limits();
    test_store_overflow();
    test_backpressure();
    test_steady_stream();
    test_random_traffic();
    idle_input();
    wait_drain();
    repeat (LINE_WALK_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/sscp_pkg.sv
design/servo_speed_command_parser.sv
design/sscp_checker.sv
tb/tb.sv
